// ----- src/m3i_pkg.sv -----
// Shared widths, stage payload types and cofactor index tables for the 3x3 inverse.
// No dependencies.
package m3i_pkg;

  localparam int DW   = 32;   // entry width
  localparam int CW   = 64;   // cofactor width
  localparam int DETW = 98;   // determinant width, signed
  localparam int RW   = 132;  // divider remainder width
  localparam int QW   = 33;   // kept quotient bits

  // cofactor k = m[CA]*m[CB] - m[CC]*m[CD]
  localparam logic [3:0] CA [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam logic [3:0] CB [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam logic [3:0] CC [9] = '{4'd5, 4'd8, 4'd2, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam logic [3:0] CD [9] = '{4'd7, 4'd1, 4'd4, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  typedef struct packed {
    logic [8:0][CW-1:0] cof;
    logic [2:0][DW-1:0] row;
  } cof_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          big;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]   lane;
    logic [RW-1:0] dv;
    logic          sing;
  } div_t;

endpackage

// ----- src/m3i_if.sv -----
// Valid/ready channel interfaces for matrix input and inverse output.
// No dependencies.
interface m3i_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] entry_00, entry_01, entry_02;
  logic signed [31:0] entry_10, entry_11, entry_12;
  logic signed [31:0] entry_20, entry_21, entry_22;
  modport source (output valid, entry_00, entry_01, entry_02, entry_10, entry_11,
                  entry_12, entry_20, entry_21, entry_22, input ready);
  modport sink   (input valid, entry_00, entry_01, entry_02, entry_10, entry_11,
                  entry_12, entry_20, entry_21, entry_22, output ready);
endinterface

interface m3i_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] inv_00, inv_01, inv_02;
  logic signed [31:0] inv_10, inv_11, inv_12;
  logic signed [31:0] inv_20, inv_21, inv_22;
  logic singular;
  logic saturated;
  modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, singular, saturated, input ready);
  modport sink   (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, singular, saturated, output ready);
endinterface

// ----- src/m3i_cofactor.sv -----
// Two-stage cofactor unit: 18 products, then nine differences.
// Depends on m3i_pkg.
module m3i_cofactor import m3i_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [8:0][DW-1:0]  mat_i,
  output logic                vld_o,
  output cof_t                cof_o
);

  logic signed [CW-1:0] pa_q [9];
  logic signed [CW-1:0] pb_q [9];
  logic [2:0][DW-1:0]   row_a_q;
  logic                 vld_a_q, vld_b_q;
  cof_t                 cof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= $signed(mat_i[CA[k]]) * $signed(mat_i[CB[k]]);
        pb_q[k] <= $signed(mat_i[CC[k]]) * $signed(mat_i[CD[k]]);
        cof_q.cof[k] <= pa_q[k] - pb_q[k];
      end
      row_a_q   <= mat_i[2:0];
      cof_q.row <= row_a_q;
    end
  end

  assign vld_o = vld_b_q;
  assign cof_o = cof_q;

endmodule

// ----- src/m3i_det.sv -----
// Determinant and divider set-up: split products, sum, magnitude, numerators.
// Depends on m3i_pkg.
module m3i_det import m3i_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  cof_t  cof_i,
  output logic  vld_o,
  output div_t  div_o
);

  localparam int SH = 2 * FRAC_BITS + 1;

  logic signed [DW+DW+1:0] plo_q [3];
  logic signed [CW-1:0]    phi_q [3];
  logic [8:0][CW-1:0]      cof_c_q, cof_d_q, mag_e_q;
  logic [8:0]              sgn_e_q;
  logic signed [DETW-1:0]  det_q, acc;
  logic [DETW-1:0]         dmag_q;
  logic                    dneg_q, sing_e_q;
  logic [3:0]              vld_q;
  div_t                    div_q, div_d;

  always_comb begin
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = acc + (DETW'(phi_q[k]) <<< 32) + DETW'(plo_q[k]);
    end
  end

  always_comb begin
    div_d.dv   = RW'(dmag_q) << 1;
    div_d.sing = sing_e_q;
    for (int k = 0; k < 9; k++) begin
      div_d.lane[k].rem = (RW'(mag_e_q[k]) << SH) + RW'(dmag_q);
      div_d.lane[k].quo = '0;
      div_d.lane[k].neg = sgn_e_q[k] ^ dneg_q;
      div_d.lane[k].big = div_d.lane[k].rem >= (div_d.dv << QW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        plo_q[k] <= $signed(cof_i.row[k]) * $signed({1'b0, cof_i.cof[3*k][DW-1:0]});
        phi_q[k] <= $signed(cof_i.row[k]) * $signed(cof_i.cof[3*k][CW-1:DW]);
      end
      cof_c_q <= cof_i.cof;
      det_q   <= acc;
      cof_d_q <= cof_c_q;
      dneg_q   <= det_q[DETW-1];
      dmag_q   <= det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
      sing_e_q <= det_q == '0;
      for (int k = 0; k < 9; k++) begin
        sgn_e_q[k] <= cof_d_q[k][CW-1];
        mag_e_q[k] <= cof_d_q[k][CW-1] ? -cof_d_q[k] : cof_d_q[k];
      end
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q[3];
  assign div_o = div_q;

endmodule

// ----- src/m3i_div_step.sv -----
// One restoring-division step for all nine lanes, one quotient bit, registered.
// Depends on m3i_pkg.
module m3i_div_step import m3i_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  div_t  div_i,
  output logic  vld_o,
  output div_t  div_o
);

  logic [RW-1:0] trial;
  logic          vld_q;
  div_t          div_d, div_q;

  always_comb begin
    trial = div_i.dv << SHIFT;
    div_d = div_i;
    for (int k = 0; k < 9; k++) begin
      if (div_i.lane[k].rem >= trial) begin
        div_d.lane[k].rem        = div_i.lane[k].rem - trial;
        div_d.lane[k].quo[SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

// ----- src/matrix3_inverse_core.sv -----
// Top level of the pipelined 3x3 fixed-point inverse.
// Depends on m3i_pkg, m3i_if, m3i_cofactor, m3i_det, m3i_div_step.
//
// in_i carries one matrix per transaction (nine signed Qx.FRAC_BITS entries);
// out_o returns its inverse, a singular flag (determinant zero, entries zero)
// and a saturated flag (some entry clamped to the 32-bit range).
// The pipeline has 2 cofactor stages, 4 determinant and set-up stages,
// 33 divider stages (one quotient bit each) and the output register.
// Throughput is one matrix per cycle while the output is not stalled; every stage holds a valid bit.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so in_i.ready = !out_o.valid || out_o.ready.
// When the receiver stalls, every stage holds and the input is refused; no
// transaction is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module matrix3_inverse_core import m3i_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  m3i_in_if.sink    in_i,
  m3i_out_if.source out_o
);

  localparam int NSTEP = QW;

  logic               en;
  logic [8:0][DW-1:0] mat;
  logic               cof_vld, det_vld;
  cof_t               cof;
  logic [NSTEP:0]     dvld;
  div_t               ddat [NSTEP+1];
  logic               out_vld_q, sing_q, sat_q, sat_d;
  logic [DW-1:0]      inv_q [9];
  logic [DW-1:0]      inv_d [9];
  logic [QW-1:0]      lim, val;
  logic               over;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  assign mat = {in_i.entry_22, in_i.entry_21, in_i.entry_20,
                in_i.entry_12, in_i.entry_11, in_i.entry_10,
                in_i.entry_02, in_i.entry_01, in_i.entry_00};

  m3i_cofactor u_cof (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid), .mat_i(mat),
    .vld_o(cof_vld), .cof_o(cof)
  );

  m3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cof_vld), .cof_i(cof),
    .vld_o(det_vld), .div_o(ddat[0])
  );

  assign dvld[0] = det_vld;

  for (genvar g = 0; g < NSTEP; g++) begin : g_div
    m3i_div_step #(.SHIFT(NSTEP - 1 - g)) u_step (
      .clk_i, .rst_ni, .en_i(en), .vld_i(dvld[g]), .div_i(ddat[g]),
      .vld_o(dvld[g+1]), .div_o(ddat[g+1])
    );
  end

  always_comb begin
    sat_d = 1'b0;
    lim   = '0;
    val   = '0;
    over  = 1'b0;
    for (int k = 0; k < 9; k++) begin
      lim  = ddat[NSTEP].lane[k].neg ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
      over = ddat[NSTEP].lane[k].big || (ddat[NSTEP].lane[k].quo > lim);
      val  = over ? lim : ddat[NSTEP].lane[k].quo;
      if (ddat[NSTEP].sing) begin
        inv_d[k] = '0;
      end else begin
        inv_d[k] = ddat[NSTEP].lane[k].neg ? DW'(-val) : DW'(val);
        sat_d    = sat_d | over;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvld[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q  <= inv_d;
      sing_q <= ddat[NSTEP].sing;
      sat_q  <= sat_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.inv_00    = inv_q[0];
  assign out_o.inv_01    = inv_q[1];
  assign out_o.inv_02    = inv_q[2];
  assign out_o.inv_10    = inv_q[3];
  assign out_o.inv_11    = inv_q[4];
  assign out_o.inv_12    = inv_q[5];
  assign out_o.inv_20    = inv_q[6];
  assign out_o.inv_21    = inv_q[7];
  assign out_o.inv_22    = inv_q[8];
  assign out_o.singular  = sing_q;
  assign out_o.saturated = sat_q;

  a_sing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sing_q |-> !sat_q && inv_q[0] == '0 && inv_q[4] == '0)
    else $error("singular result not cleared");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(sat_q) && $stable(sing_q))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted during output stall");

endmodule

// ----- tb/tb_matrix3_inverse_core.sv -----
// Self-checking testbench for matrix3_inverse_core: directed and random 3x3 matrices.
// Predicts each inverse with exact wide integer arithmetic; depends on m3i_if and the core.
`timescale 1ns / 1ps
module tb_matrix3_inverse_core;

  localparam int FRAC      = 16;
  localparam int N_RANDOM  = 1230;
  localparam int MAX_CYCLE = 1000000;

  typedef struct packed {
    logic [8:0][31:0] e;
  } mat_t;

  typedef struct packed {
    logic [8:0][31:0] inv;
    logic             sing;
    logic             sat;
  } inv_t;

  logic clk_i;
  logic rst_ni;
  m3i_in_if  in_if ();
  m3i_out_if out_if ();

  matrix3_inverse_core #(.FRAC_BITS(FRAC)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mat_t       matrix_q[$];
  inv_t       inverse_q[$];
  int         cycle_cnt;
  int         fail_cnt;
  int         send_gap;
  int         take_stall;
  int         hold_left;
  bit         quiet;

  always #2 clk_i = ~clk_i;

  function automatic inv_t invert(mat_t m);
    longint                a[9];
    longint                c[9];
    logic signed [127:0]   pa, pc, det;
    logic [127:0]          dmag;
    logic [191:0]          num, den, q;
    logic [63:0]           cm;
    logic [31:0]           lim, v;
    bit                    dneg, neg;
    inv_t                  r;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(m.e[i]));
    c[0] = a[4] * a[8] - a[5] * a[7];
    c[1] = a[7] * a[2] - a[8] * a[1];
    c[2] = a[1] * a[5] - a[2] * a[4];
    c[3] = a[6] * a[5] - a[3] * a[8];
    c[4] = a[0] * a[8] - a[6] * a[2];
    c[5] = a[3] * a[2] - a[0] * a[5];
    c[6] = a[3] * a[7] - a[6] * a[4];
    c[7] = a[6] * a[1] - a[0] * a[7];
    c[8] = a[0] * a[4] - a[3] * a[1];
    det = '0;
    for (int k = 0; k < 3; k++) begin
      pa  = a[k];
      pc  = c[3 * k];
      det = det + pa * pc;
    end
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    dneg = det[127];
    dmag = dneg ? -det : det;
    den  = {64'd0, dmag} << 1;
    for (int i = 0; i < 9; i++) begin
      neg = (c[i] < 0) != dneg;
      cm  = c[i] < 0 ? -c[i] : c[i];
      num = ({128'd0, cm} << (2 * FRAC + 1)) + {64'd0, dmag};
      q   = num / den;
      lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      if (q > {160'd0, lim}) begin
        v     = lim;
        r.sat = 1'b1;
      end else begin
        v = q[31:0];
      end
      r.inv[i] = neg ? -v : v;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] srand(int unsigned mag);
    logic [31:0] x;
    x = $urandom_range(0, mag);
    return $urandom_range(0, 1) ? -x : x;
  endfunction

  function automatic mat_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    mat_t m;
    m      = '0;
    m.e[0] = d0;
    m.e[4] = d1;
    m.e[8] = d2;
    return m;
  endfunction

  function automatic mat_t rand_matrix();
    mat_t        m;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 40) m.e[i] = (i % 4 == 0) ? srand(1 << 18) : srand(1 << 14);
      else if (kind < 60) m.e[i] = srand(1 << 12);
      else m.e[i] = $urandom;
    end
    if (kind < 40) begin
      for (int i = 0; i < 9; i += 4)
        if ($signed(m.e[i]) >= 0) m.e[i] = m.e[i] + (1 << 15);
        else m.e[i] = m.e[i] - (1 << 15);
    end
    if (kind >= 85) begin
      case ($urandom_range(0, 2))
        0: for (int j = 0; j < 3; j++) m.e[6 + j] = m.e[j];
        1: for (int j = 0; j < 3; j++) m.e[3 * j + 1] = '0;
        default: for (int j = 0; j < 3; j++) m.e[3 + j] = -m.e[j];
      endcase
    end
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mat_t m;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (matrix_q.size() > 0) begin
        m = matrix_q.pop_front();
        inverse_q.push_back(invert(m));
        {in_if.entry_22, in_if.entry_21, in_if.entry_20,
         in_if.entry_12, in_if.entry_11, in_if.entry_10,
         in_if.entry_02, in_if.entry_01, in_if.entry_00} <= m.e;
        in_if.valid <= 1'b1;
        send_gap    <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and back-pressures the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (cycle_cnt == 2000) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    inv_t        exp_r;
    logic [31:0] got [9];
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_stall   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.inv_00, out_if.inv_01, out_if.inv_02,
                out_if.inv_10, out_if.inv_11, out_if.inv_12,
                out_if.inv_20, out_if.inv_21, out_if.inv_22};
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected output transaction", $time);
          fail_cnt = fail_cnt + 1;
        end else begin
          exp_r = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== exp_r.inv[i]) begin
              $display("%0t: inv[%0d] expected %h actual %h", $time, i, exp_r.inv[i], got[i]);
              fail_cnt = fail_cnt + 1;
            end
          if (out_if.singular !== exp_r.sing || out_if.saturated !== exp_r.sat) begin
            $display("%0t: flags sing/sat expected %b%b actual %b%b", $time,
                     exp_r.sing, exp_r.sat, out_if.singular, out_if.saturated);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
      if (take_stall > 0) begin
        out_if.ready <= 1'b0;
        take_stall   <= take_stall - 1;
      end else if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        take_stall   <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 500 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= MAX_CYCLE) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mat_t m;
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    cycle_cnt = 0;
    fail_cnt  = 0;
    quiet     = 1'b0;
    in_if.valid = 1'b0;
    {in_if.entry_00, in_if.entry_01, in_if.entry_02, in_if.entry_10, in_if.entry_11,
     in_if.entry_12, in_if.entry_20, in_if.entry_21, in_if.entry_22} = '0;
    out_if.ready = 1'b0;

    matrix_q.push_back(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
    matrix_q.push_back(diag(32'h2_0000, 32'hffff_0000, 32'h0_4000));
    matrix_q.push_back(diag(32'h0_0001, 32'h1_0000, 32'h1_0000));
    matrix_q.push_back(diag(32'h0_0001, 32'hffff_ffff, 32'h0_0003));
    matrix_q.push_back(diag(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    matrix_q.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    matrix_q.push_back(diag(32'h0_0003, 32'h0_0003, 32'h0_0003));
    matrix_q.push_back('0);
    m.e = {9{32'h7fff_ffff}};
    matrix_q.push_back(m);
    m.e = {9{32'h8000_0000}};
    matrix_q.push_back(m);
    // full-scale entries; cofactors reach 2**62 in magnitude but stay in the 64-bit range
    m.e = {32'h1_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000,
           32'h0, 32'h8000_0000, 32'h0, 32'h1_0000};
    matrix_q.push_back(m);
    m.e = {32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 32'h0};
    matrix_q.push_back(m);
    m.e = {32'h3_0000, 32'h2_0000, 32'h1_0000, 32'h6_0000, 32'h4_0000,
           32'h2_0000, 32'h1_0000, 32'h5_0000, 32'h7_0000};
    matrix_q.push_back(m);
    m.e = {32'h1_8000, 32'hffff_8000, 32'h0_2000, 32'h0_1000, 32'h2_0000,
           32'hfffe_0000, 32'h0, 32'h0_4000, 32'h1_0000};
    matrix_q.push_back(m);
    m.e = {32'h0_0002, 32'h0_0001, 32'h0_0001, 32'h0_0001, 32'h0_0002,
           32'h0_0001, 32'h0_0001, 32'h0_0001, 32'h0_0002};
    matrix_q.push_back(m);
    for (int i = 0; i < N_RANDOM; i++) matrix_q.push_back(rand_matrix());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (matrix_q.size() == 0 && !in_if.valid && inverse_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && inverse_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
